### sv/iit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iit_pkg;

  // Default sizes handed to the top level
  localparam int DEF_PAIR_DEPTH  = 256;
  localparam int DEF_SPLIT_DEPTH = 256;
  localparam int DEF_ID_WIDTH    = 16;

  localparam int STATUS_W = 2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

  // Request kinds
  localparam logic MODE_PAIR  = 1'b0;
  localparam logic MODE_SPLIT = 1'b1;

  // Control half of the search token that walks along a chain
  typedef struct packed {
    logic valid;
    logic hit;
  } tok_ctl_t;

endpackage

`default_nettype wire

### sv/iit_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One table entry plus one stage of the search token path.
module iit_cell #(
  parameter int DEPTH = iit_pkg::DEF_PAIR_DEPTH,
  parameter int INDEX = 0,
  parameter int KEY_W = 2 * iit_pkg::DEF_ID_WIDTH,
  parameter int VAL_W = iit_pkg::DEF_ID_WIDTH
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire  iit_pkg::tok_ctl_t      ctl_in,
  input  wire  [KEY_W-1:0]             key_in,
  input  wire  [VAL_W-1:0]             val_in,
  output iit_pkg::tok_ctl_t            ctl_out,
  output logic [KEY_W-1:0]             key_out,
  output logic [VAL_W-1:0]             val_out,
  input  wire  [$clog2(DEPTH+1)-1:0]   count,
  input  wire                          wr_en,
  input  wire  [$clog2(DEPTH)-1:0]     wr_index,
  input  wire  [KEY_W-1:0]             wr_key,
  input  wire  [VAL_W-1:0]             wr_val
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  logic [KEY_W-1:0] entry_key;
  logic [VAL_W-1:0] entry_val;
  logic             live;
  logic             hit_here;

  // Only entries below the fill count take part in the search
  assign live     = count > CNT_W'(INDEX);
  assign hit_here = live && (entry_key == key_in);

  always_ff @(posedge clk) begin
    if (wr_en && (wr_index == IDX_W'(INDEX))) begin
      entry_key <= wr_key;
      entry_val <= wr_val;
    end
  end

  // Advance the token one cell; keep the first hit's value
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
      ctl_out.hit   <= ctl_in.hit | hit_here;
    end
  end

  always_ff @(posedge clk) begin
    key_out <= key_in;
    val_out <= ctl_in.hit ? val_in : entry_val;
  end

endmodule

`default_nettype wire

### sv/iit_chain.sv
`timescale 1ns / 1ps
`default_nettype none

// Row of cells; a search token enters at cell 0 and leaves after passing through all DEPTH cells.
module iit_chain #(
  parameter int DEPTH = iit_pkg::DEF_PAIR_DEPTH,
  parameter int KEY_W = 2 * iit_pkg::DEF_ID_WIDTH,
  parameter int VAL_W = iit_pkg::DEF_ID_WIDTH
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire  iit_pkg::tok_ctl_t      launch_ctl,
  input  wire  [KEY_W-1:0]             launch_key,
  output iit_pkg::tok_ctl_t            exit_ctl,
  output logic [VAL_W-1:0]             exit_val,
  input  wire  [$clog2(DEPTH+1)-1:0]   count,
  input  wire                          wr_en,
  input  wire  [$clog2(DEPTH)-1:0]     wr_index,
  input  wire  [KEY_W-1:0]             wr_key,
  input  wire  [VAL_W-1:0]             wr_val
);

  iit_pkg::tok_ctl_t  ctl [DEPTH+1];
  logic [KEY_W-1:0]   key [DEPTH+1];
  logic [VAL_W-1:0]   val [DEPTH+1];

  assign ctl[0] = launch_ctl;
  assign key[0] = launch_key;
  assign val[0] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    iit_cell #(
      .DEPTH (DEPTH),
      .INDEX (g),
      .KEY_W (KEY_W),
      .VAL_W (VAL_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl_in   (ctl[g]),
      .key_in   (key[g]),
      .val_in   (val[g]),
      .ctl_out  (ctl[g+1]),
      .key_out  (key[g+1]),
      .val_out  (val[g+1]),
      .count    (count),
      .wr_en    (wr_en),
      .wr_index (wr_index),
      .wr_key   (wr_key),
      .wr_val   (wr_val)
    );
  end

  assign exit_ctl = ctl[DEPTH];
  assign exit_val = val[DEPTH];

endmodule

`default_nettype wire

### sv/innovation_id_table_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake                         | Beat contents
// --------+-----------------------------------+-----------------------------------------
// in      | in_valid / in_stall (we drive)    | mode, first_node, second_node,
//         |                                   | split_connection
// out     | out_valid / out_stall (sink)      | number_first, number_second, was_known,
//         |                                   | status
//
// Flow: one request at a time; after acceptance the search token launches and walks
//   the cell chain of the addressed table one cell per cycle, then the result is
//   captured and committed. The next request is taken only once the last one has
//   been committed.
// Reset: rst (synchronous, active high) empties both tables and sets the number
//   counter to 1; entry contents are left as they are and no clearing pass runs.
// Stalls: in_stall is high while a request is being searched or committed; a
//   finished result waits in the output register while the next request is taken,
//   and a commit holds off until that register is free.
module innovation_id_table_core #(
  parameter int PAIR_DEPTH  = iit_pkg::DEF_PAIR_DEPTH,
  parameter int SPLIT_DEPTH = iit_pkg::DEF_SPLIT_DEPTH,
  parameter int ID_WIDTH    = iit_pkg::DEF_ID_WIDTH
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire                           mode,
  input  wire  [ID_WIDTH-1:0]           first_node,
  input  wire  [ID_WIDTH-1:0]           second_node,
  input  wire  [ID_WIDTH-1:0]           split_connection,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [ID_WIDTH-1:0]           number_first,
  output logic [ID_WIDTH-1:0]           number_second,
  output logic                          was_known,
  output logic [iit_pkg::STATUS_W-1:0]  status
);

  localparam int PCNT_W = $clog2(PAIR_DEPTH + 1);
  localparam int SCNT_W = $clog2(SPLIT_DEPTH + 1);
  localparam int PIDX_W = $clog2(PAIR_DEPTH);
  localparam int SIDX_W = $clog2(SPLIT_DEPTH);
  localparam logic [ID_WIDTH-1:0] ONE = ID_WIDTH'(1);
  localparam logic [ID_WIDTH-1:0] TWO = ID_WIDTH'(2);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_SEARCH,
    S_DONE
  } state_t;

  state_t state;

  // Latched request
  logic                  req_mode;
  logic [ID_WIDTH-1:0]   req_first;
  logic [ID_WIDTH-1:0]   req_second;
  logic [ID_WIDTH-1:0]   req_split;

  // Search outcome
  logic                  res_hit;
  logic [ID_WIDTH-1:0]   res_pair_val;
  logic [2*ID_WIDTH-1:0] res_split_val;

  // Table bookkeeping
  logic [PCNT_W-1:0]     pair_count;
  logic [SCNT_W-1:0]     split_count;
  logic [ID_WIDTH-1:0]   next_number;

  logic [PCNT_W-1:0]     pair_count_next;
  logic [SCNT_W-1:0]     split_count_next;
  logic [ID_WIDTH-1:0]   next_number_next;

  // Commit decision
  logic                  pair_ins;
  logic                  split_ins;
  logic [ID_WIDTH-1:0]   first_next;
  logic [ID_WIDTH-1:0]   second_next;
  logic                  known_next;
  logic [iit_pkg::STATUS_W-1:0] status_next;
  logic                  finish;

  iit_pkg::tok_ctl_t     pair_launch;
  iit_pkg::tok_ctl_t     split_launch;
  iit_pkg::tok_ctl_t     pair_exit;
  iit_pkg::tok_ctl_t     split_exit;
  logic [ID_WIDTH-1:0]   pair_exit_val;
  logic [2*ID_WIDTH-1:0] split_exit_val;

  assign in_stall = (state != S_IDLE);
  assign finish   = (state == S_DONE) && (!out_valid || !out_stall);

  // Launch the token into the chain of the addressed table only
  assign pair_launch.valid  = (state == S_LAUNCH) && (req_mode == iit_pkg::MODE_PAIR);
  assign pair_launch.hit    = 1'b0;
  assign split_launch.valid = (state == S_LAUNCH) && (req_mode == iit_pkg::MODE_SPLIT);
  assign split_launch.hit   = 1'b0;

  iit_chain #(
    .DEPTH (PAIR_DEPTH),
    .KEY_W (2 * ID_WIDTH),
    .VAL_W (ID_WIDTH)
  ) u_pair_chain (
    .clk        (clk),
    .rst        (rst),
    .launch_ctl (pair_launch),
    .launch_key ({req_first, req_second}),
    .exit_ctl   (pair_exit),
    .exit_val   (pair_exit_val),
    .count      (pair_count),
    .wr_en      (finish && pair_ins),
    .wr_index   (pair_count[PIDX_W-1:0]),
    .wr_key     ({req_first, req_second}),
    .wr_val     (next_number)
  );

  iit_chain #(
    .DEPTH (SPLIT_DEPTH),
    .KEY_W (ID_WIDTH),
    .VAL_W (2 * ID_WIDTH)
  ) u_split_chain (
    .clk        (clk),
    .rst        (rst),
    .launch_ctl (split_launch),
    .launch_key (req_split),
    .exit_ctl   (split_exit),
    .exit_val   (split_exit_val),
    .count      (split_count),
    .wr_en      (finish && split_ins),
    .wr_index   (split_count[SIDX_W-1:0]),
    .wr_key     (req_split),
    .wr_val     ({next_number, next_number + ONE})
  );

  // Decide the result: a known key wins, then table full, then counter exhausted
  always_comb begin
    pair_ins         = 1'b0;
    split_ins        = 1'b0;
    first_next       = '0;
    second_next      = '0;
    known_next       = 1'b0;
    status_next      = iit_pkg::ST_OK;
    pair_count_next  = pair_count;
    split_count_next = split_count;
    next_number_next = next_number;
    if (req_mode == iit_pkg::MODE_PAIR) begin
      priority if (res_hit) begin
        first_next = res_pair_val;
        known_next = 1'b1;
      end else if (pair_count == PCNT_W'(PAIR_DEPTH)) begin
        status_next = iit_pkg::ST_FULL;
      end else if (next_number == '0) begin
        status_next = iit_pkg::ST_EXHAUSTED;
      end else begin
        pair_ins         = 1'b1;
        first_next       = next_number;
        pair_count_next  = pair_count + PCNT_W'(1);
        next_number_next = next_number + ONE;
      end
    end else begin
      priority if (res_hit) begin
        first_next  = res_split_val[2*ID_WIDTH-1:ID_WIDTH];
        second_next = res_split_val[ID_WIDTH-1:0];
        known_next  = 1'b1;
      end else if (split_count == SCNT_W'(SPLIT_DEPTH)) begin
        status_next = iit_pkg::ST_FULL;
      end else if ((next_number == '0) || (next_number == '1)) begin
        status_next = iit_pkg::ST_EXHAUSTED;
      end else begin
        split_ins        = 1'b1;
        first_next       = next_number;
        second_next      = next_number + ONE;
        split_count_next = split_count + SCNT_W'(1);
        next_number_next = next_number + TWO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      pair_count  <= '0;
      split_count <= '0;
      next_number <= ONE;
    end else begin
      // Load a fresh output beat on commit, else drop the current one once taken
      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_mode   <= mode;
            req_first  <= first_node;
            req_second <= second_node;
            req_split  <= split_connection;
            state      <= S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          state <= S_SEARCH;
        end
        S_SEARCH: begin
          // Hold until the token leaves the end of its chain
          if (pair_exit.valid || split_exit.valid) begin
            res_hit       <= pair_exit.valid ? pair_exit.hit : split_exit.hit;
            res_pair_val  <= pair_exit_val;
            res_split_val <= split_exit_val;
            state         <= S_DONE;
          end
        end
        S_DONE: begin
          if (finish) begin
            number_first  <= first_next;
            number_second <= second_next;
            was_known     <= known_next;
            status        <= status_next;
            pair_count    <= pair_count_next;
            split_count   <= split_count_next;
            next_number   <= next_number_next;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Fill counts never pass their table depths
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (pair_count <= PCNT_W'(PAIR_DEPTH)) && (split_count <= SCNT_W'(SPLIT_DEPTH)))
    else $error("table fill count beyond depth");

  // A good result never carries number zero
  a_no_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == iit_pkg::ST_OK)) |-> (number_first != '0))
    else $error("number zero issued");

  // Only one chain carries a token at a time
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    !(pair_exit.valid && split_exit.valid))
    else $error("tokens leave both chains together");

  // An accepted beat blocks the input until it is committed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a request is in flight");

endmodule

`default_nettype wire
